@@ rtl/core/trss_pkg.sv @@
`default_nettype none

package trss_pkg;

    // Default number of slots and the reset value of the look-ahead window.
    localparam int unsigned SLOT_COUNT_DEF = 16;
    localparam logic [15:0] HORIZON_RESET  = 16'h8000;

    // Field widths fixed by the interface.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned HOR_W   = 16;
    localparam int unsigned LIMIT_W = TIME_W + 1;

    // Configuration port: one 16-bit register, read zero-extended to 32 bits, at byte address 0.
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned DATA_W     = 32;
    localparam logic [0:0]  REG_HORIZON = 1'b0;

    // Slot memory word: due time, packet id and tries.
    localparam int unsigned SLOT_WORD_W = TIME_W + 2 * BYTE_W;

    typedef enum logic
    {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t             opcode;
        logic [TIME_W-1:0]   time_value;
        logic [BYTE_W-1:0]   packet_id;
        logic [BYTE_W-1:0]   packet_length;
        logic [BYTE_W-1:0]   max_tries;
    } req_t;

    typedef struct packed
    {
        opcode_t             reply_kind;
        logic                accepted;
        logic [SLOT_W-1:0]   slot_index;
        logic                released;
        logic [BYTE_W-1:0]   out_id;
        logic [BYTE_W-1:0]   out_length;
        logic [BYTE_W-1:0]   out_tries;
    } rsp_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ADD,
        ST_TICK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic load;
        logic add_step;
        logic tick_step;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic add_hit;
        logic last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

@@ rtl/core/trss_ram.sv @@
`default_nettype none

module trss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/trss_ctrl.sv @@
`default_nettype none

module trss_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire trss_pkg::opcode_t in_op,
    output logic                  in_ready,
    output trss_pkg::cmd_t        cmd,
    input  wire trss_pkg::sts_t   sts
);

    trss_pkg::state_t state_reg;
    trss_pkg::state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trss_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            trss_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = (in_op == trss_pkg::OP_TICK) ? trss_pkg::ST_TICK
                                                              : trss_pkg::ST_ADD;
                end
            end
            trss_pkg::ST_ADD:
            begin
                cmd.add_step = 1'b1;
                if (sts.add_hit || sts.last)
                begin
                    state_next = trss_pkg::ST_FINISH;
                end
            end
            trss_pkg::ST_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (sts.last)
                begin
                    state_next = trss_pkg::ST_DRAIN;
                end
            end
            trss_pkg::ST_DRAIN:
            begin
                // The last slot read is compared in this cycle.
                state_next = trss_pkg::ST_FINISH;
            end
            trss_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = trss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trss_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/trss_dp.sv @@
`default_nettype none

module trss_dp #(
    parameter int unsigned SLOT_COUNT = trss_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire trss_pkg::cmd_t               cmd,
    output trss_pkg::sts_t                    sts,
    input  wire trss_pkg::req_t               in_req,
    input  wire logic [trss_pkg::HOR_W-1:0]   horizon,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output trss_pkg::rsp_t                    out_rsp
);

    localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned ExtW = IdxW + trss_pkg::SLOT_W;
    localparam int unsigned TW   = trss_pkg::TIME_W;
    localparam int unsigned BW   = trss_pkg::BYTE_W;
    localparam int unsigned LW   = trss_pkg::LIMIT_W;
    localparam int unsigned WW   = trss_pkg::SLOT_WORD_W;

    trss_pkg::req_t     item_reg;
    logic [IdxW-1:0]    idx_reg;
    logic [LW-1:0]      limit_reg;
    logic               found_reg;
    logic [IdxW-1:0]    best_idx_reg;
    logic [BW-1:0]      best_id_reg;
    logic [BW-1:0]      best_len_reg;
    logic [BW-1:0]      best_tries_reg;
    logic               pipe_vld_reg;
    logic               pipe_live_reg;
    logic [IdxW-1:0]    pipe_idx_reg;
    logic [BW-1:0]      pipe_len_reg;
    logic [BW-1:0]      len_reg [SLOT_COUNT];
    logic               out_valid_reg;
    trss_pkg::rsp_t     out_rsp_reg;

    logic               add_hit;
    logic               last;
    logic               ram_we;
    logic [WW-1:0]      ram_wdata;
    logic [WW-1:0]      ram_rdata;
    logic [TW-1:0]      rd_due;
    logic               cand;
    logic               release_ok;
    logic [ExtW-1:0]    best_ext;
    trss_pkg::rsp_t     rsp;

    // Slot scan status.
    assign add_hit      = (len_reg[idx_reg] == '0);
    assign last         = (idx_reg == IdxW'(SLOT_COUNT - 1));
    assign sts.add_hit  = add_hit;
    assign sts.last     = last;
    assign sts.out_free = !out_valid_reg || out_ready;

    // Slot memory holds due time, id and tries; lengths stay in flops.
    assign ram_we    = cmd.add_step && add_hit;
    assign ram_wdata = {item_reg.time_value, item_reg.packet_id, item_reg.max_tries};

    trss_ram #(
        .WIDTH (WW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // A live slot read last cycle beats the current limit when strictly earlier.
    assign rd_due = ram_rdata[WW-1 -: TW];
    assign cand   = pipe_vld_reg && pipe_live_reg && ({1'b0, rd_due} < limit_reg);

    // The chosen slot is released when its due time is at or before now.
    assign release_ok = found_reg && (limit_reg <= {1'b0, item_reg.time_value});
    assign best_ext   = {{trss_pkg::SLOT_W{1'b0}}, best_idx_reg};

    // Result assembly.
    always_comb
    begin
        rsp = '0;
        rsp.reply_kind = item_reg.opcode;
        if (item_reg.opcode == trss_pkg::OP_ADD)
        begin
            rsp.accepted = found_reg;
            if (found_reg)
            begin
                rsp.slot_index = best_ext[trss_pkg::SLOT_W-1:0];
            end
        end
        else if (release_ok)
        begin
            rsp.released   = 1'b1;
            rsp.slot_index = best_ext[trss_pkg::SLOT_W-1:0];
            rsp.out_id     = best_id_reg;
            rsp.out_length = best_len_reg;
            rsp.out_tries  = best_tries_reg;
        end
    end

    // Control state: scan index, search flags, slot lengths, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            pipe_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            pipe_vld_reg <= cmd.tick_step;
            if (cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.add_step)
            begin
                if (add_hit)
                begin
                    found_reg        <= 1'b1;
                    len_reg[idx_reg] <= item_reg.packet_length;
                end
                else if (!last)
                begin
                    idx_reg <= idx_reg + IdxW'(1);
                end
            end
            else if (cmd.tick_step)
            begin
                idx_reg <= idx_reg + IdxW'(1);
            end
            if (cand)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish && (item_reg.opcode == trss_pkg::OP_TICK) && release_ok)
            begin
                len_reg[best_idx_reg] <= '0;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg  <= in_req;
            limit_reg <= {1'b0, in_req.time_value} + LW'(horizon);
        end
        if (cmd.add_step && add_hit)
        begin
            best_idx_reg <= idx_reg;
        end
        if (cmd.tick_step)
        begin
            pipe_idx_reg  <= idx_reg;
            pipe_len_reg  <= len_reg[idx_reg];
            pipe_live_reg <= (len_reg[idx_reg] != '0);
        end
        if (cand)
        begin
            limit_reg      <= {1'b0, rd_due};
            best_idx_reg   <= pipe_idx_reg;
            best_len_reg   <= pipe_len_reg;
            best_id_reg    <= ram_rdata[2*BW-1 -: BW];
            best_tries_reg <= ram_rdata[BW-1:0];
        end
        if (cmd.finish)
        begin
            out_rsp_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_rsp_reg;

endmodule

`default_nettype wire

@@ rtl/core/timed_release_slot_scheduler.sv @@
`default_nettype none

// Timed release slot scheduler. An add request stores a packet's due time, id,
// length and tries in the lowest free slot; a tick request carries the current
// time and releases the slot with the earliest due time inside the look-ahead
// window when that time has come. Exactly one response follows each request.
// Requests are handled one at a time by a scan over the slot memory, one slot
// per cycle through its single read port: an add stops at the first free slot,
// a tick scans every slot. A response waits in an output register, and the
// next request is taken as soon as the previous one has moved there. The
// horizon register sits at byte address 0 of the configuration port.
module timed_release_slot_scheduler #(
    parameter int unsigned SLOT_COUNT = trss_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire trss_pkg::req_t                in_req,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output trss_pkg::rsp_t                     out_rsp,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [trss_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [trss_pkg::DATA_W-1:0]   pwdata,
    output logic      [trss_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    logic [trss_pkg::HOR_W-1:0] horizon_reg;
    logic                       reg_sel;
    trss_pkg::cmd_t             cmd;
    trss_pkg::sts_t             sts;

    // Configuration register: written in the access phase of a write.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[trss_pkg::ADDR_W-1:2] == trss_pkg::REG_HORIZON);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg <= trss_pkg::HORIZON_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            horizon_reg <= pwdata[trss_pkg::HOR_W-1:0];
        end
    end

    assign prdata = reg_sel ? trss_pkg::DATA_W'(horizon_reg) : '0;

    // Sequencer.
    trss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_op    (in_req.opcode),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Slot storage, search and response register.
    trss_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_req    (in_req),
        .horizon   (horizon_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_rsp   (out_rsp)
    );

endmodule

`default_nettype wire

@@ rtl/core/trss_checker.sv @@
`default_nettype none

module trss_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire trss_pkg::req_t  in_req,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire trss_pkg::rsp_t  out_rsp
);

    // A waiting response holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_rsp))
        else $error("response changed while stalled");

    // Only one request is in work at a time.
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in work");

    // An add response carries no released packet.
    a_add_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_rsp.reply_kind == trss_pkg::OP_ADD) |->
            !out_rsp.released && (out_rsp.out_id == '0) &&
            (out_rsp.out_length == '0) && (out_rsp.out_tries == '0) &&
            (out_rsp.accepted || (out_rsp.slot_index == '0)))
        else $error("add response carries tick fields");

    // A tick never accepts, and a released packet always has a length.
    a_tick_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_rsp.reply_kind == trss_pkg::OP_TICK) |->
            !out_rsp.accepted && (!out_rsp.released || (out_rsp.out_length != '0)))
        else $error("tick response inconsistent");

endmodule

bind timed_release_slot_scheduler trss_checker u_trss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
);

`default_nettype wire
